// ----- rtl/s256_pkg.sv -----
// shared types, constants and round functions for the sha-256 byte hasher
`timescale 1ns / 1ps
package s256_pkg;

	localparam int ROUNDS_DEF = 64;

	localparam logic [31:0] RC_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TABLE [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} ctl_state_t;

	// controller to compression core
	typedef struct packed {
		logic start;
		logic add_iv;
	} core_cmd_t;

	// compression core to controller
	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- rtl/s256_core.sv -----
// compression core: schedule memory, round registers and chain value memory
`timescale 1ns / 1ps
module s256_core #(
	parameter int ROUNDS = s256_pkg::ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  s256_pkg::core_cmd_t cmd,
	output s256_pkg::core_sts_t sts,
	// block word writes from the controller
	input  logic                blk_we,
	input  logic [3:0]          blk_addr,
	input  logic [31:0]         blk_wdata,
	// chain value readout
	input  logic [2:0]          cv_raddr,
	output logic [31:0]         cv_rdata,
	input  logic                cv_reinit
);
	import s256_pkg::*;

	localparam int RW = $clog2(ROUNDS + 1);

	// window memory: 16 message schedule words
	logic [31:0] win_mem [16];
	// chain value memory
	logic [31:0] cv_mem [8];

	typedef enum logic [2:0] {
		C_IDLE, C_LDCV, C_SCH, C_RND, C_FIN
	} cst_t;
	cst_t cst_q;

	logic [RW-1:0] t_q;
	logic [4:0]    k_q;
	logic [31:0]   a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0]   x2_q, x7_q, x15_q, x16_q, w_q;
	logic [31:0]   cv_rd_q;
	logic [7:0]    cv_init_q;
	logic [31:0]   t1, t2, wnew;
	logic [5:0]    tr;

	assign tr = t_q[5:0];
	assign wnew = ssig1(x2_q) + x7_q + ssig0(x15_q) + x16_q;
	assign t1 = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + RC_TABLE[tr] + w_q;
	assign t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// chain value read port, shared by readout and the core; reinit marks
	// make an entry read as iv until rewritten
	logic [2:0]  cv_ra, cv_ra_s1;
	logic [31:0] cv_val;
	assign cv_ra = (cst_q == C_IDLE) ? cv_raddr : k_q[2:0];
	always_ff @(posedge clk) begin
		cv_rd_q  <= cv_mem[cv_ra];
		cv_ra_s1 <= cv_ra;
	end
	assign cv_val   = cv_init_q[cv_ra_s1] ? IV_TABLE[cv_ra_s1] : cv_rd_q;
	assign cv_rdata = cv_val;

	// window memory access: read the four schedule taps in turn, write one word
	logic [3:0]  wr_a;
	logic [31:0] win_rd_q;
	logic [3:0]  rd_a;
	always_comb begin
		case (k_q[1:0])
			2'd0:    rd_a = tr[3:0] - 4'd2;
			2'd1:    rd_a = tr[3:0] - 4'd7;
			2'd2:    rd_a = tr[3:0] - 4'd15;
			default: rd_a = tr[3:0];
		endcase
		if (cst_q != C_SCH || t_q < RW'(16)) rd_a = tr[3:0];
	end
	assign wr_a = blk_we ? blk_addr : tr[3:0];
	always_ff @(posedge clk) begin
		win_rd_q <= win_mem[rd_a];
		if (blk_we) win_mem[wr_a] <= blk_wdata;
		else if (cst_q == C_SCH && k_q == 5'd5) win_mem[wr_a] <= wnew;
	end

	assign sts.busy = (cst_q != C_IDLE);
	assign sts.done = (cst_q == C_FIN) && (k_q == 5'd8);

	// core sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q     <= C_IDLE;
			t_q       <= '0;
			k_q       <= '0;
			cv_init_q <= '1;
		end else begin
			if (cv_reinit) cv_init_q <= '1;
			unique case (cst_q)
				C_IDLE: begin
					if (cmd.start) begin
						cst_q <= C_LDCV;
						k_q   <= '0;
						t_q   <= '0;
					end
				end
				C_LDCV: begin
					// k 0..7 issue reads, k 1..8 take the data
					k_q <= k_q + 5'd1;
					if (k_q == 5'd8) begin
						k_q   <= '0;
						cst_q <= C_SCH;
					end
				end
				C_SCH: begin
					// k 1..4 capture taps; k 5 compute/write; under 16 just one read
					k_q <= k_q + 5'd1;
					if (t_q < RW'(16) && k_q == 5'd1) begin
						k_q   <= '0;
						cst_q <= C_RND;
					end else if (k_q == 5'd5) begin
						k_q   <= '0;
						cst_q <= C_RND;
					end
				end
				C_RND: begin
					t_q <= t_q + RW'(1);
					if (t_q == RW'(ROUNDS - 1)) begin
						cst_q <= C_FIN;
						k_q   <= '0;
					end else cst_q <= C_SCH;
				end
				C_FIN: begin
					// read entry k, write back entry k-1 read the cycle before
					k_q <= k_q + 5'd1;
					if (k_q != 5'd0) cv_init_q[cv_ra_s1] <= 1'b0;
					if (k_q == 5'd8) begin
						cst_q <= C_IDLE;
						k_q   <= '0;
					end
				end
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	// chain value memory write-back: add working vars into chain value
	logic [31:0] fin_add;
	always_comb begin
		case (cv_ra_s1)
			3'd0:    fin_add = a_q;
			3'd1:    fin_add = b_q;
			3'd2:    fin_add = c_q;
			3'd3:    fin_add = d_q;
			3'd4:    fin_add = e_q;
			3'd5:    fin_add = f_q;
			3'd6:    fin_add = g_q;
			default: fin_add = h_q;
		endcase
	end
	always_ff @(posedge clk) begin
		if (cst_q == C_FIN && k_q != 5'd0) cv_mem[cv_ra_s1] <= cv_val + fin_add;
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cst_q == C_LDCV && k_q != 5'd0) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <=
				{b_q, c_q, d_q, e_q, f_q, g_q, h_q, cv_val};
		end
		if (cst_q == C_SCH) begin
			if (t_q < RW'(16)) begin
				if (k_q == 5'd1) w_q <= win_rd_q;
			end else begin
				case (k_q)
					5'd1: x2_q  <= win_rd_q;
					5'd2: x7_q  <= win_rd_q;
					5'd3: x15_q <= win_rd_q;
					5'd4: x16_q <= win_rd_q;
					5'd5: w_q   <= wnew;
					default: ;
				endcase
			end
		end
		if (cst_q == C_RND) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
	end
endmodule

// ----- rtl/s256_ctl.sv -----
// input packing, padding and digest output sequencing
`timescale 1ns / 1ps
module s256_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          msg_byte,
	input  logic                has_byte,
	input  logic                end_of_message,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_index,
	output logic                last_word,
	output s256_pkg::core_cmd_t cmd,
	input  s256_pkg::core_sts_t sts,
	output logic                blk_we,
	output logic [3:0]          blk_addr,
	output logic [31:0]         blk_wdata,
	output logic [2:0]          cv_raddr,
	input  logic [31:0]         cv_rdata,
	output logic                cv_reinit
);
	import s256_pkg::*;

	ctl_state_t st_q, st_d;
	logic [60:0] cnt_q;
	logic [31:0] acc_q;
	logic [5:0]  pos_q;
	logic        fin_q, need_len_q, run_q;
	logic [3:0]  rd_q;
	logic        rd_pend_q;
	logic        accept, byte_acc;
	logic [63:0] bits;
	logic [5:0]  cur;
	logic        pad_go;

	assign accept   = in_valid && !in_stall;
	assign byte_acc = accept && has_byte;
	assign bits     = {cnt_q, 3'b000};
	assign cur      = cnt_q[5:0];
	assign in_stall = (st_q != ST_IDLE) || sts.busy || run_q;
	// padding waits while the core still works on the previous block
	assign pad_go   = (st_q == ST_PAD || st_q == ST_LEN) && !sts.busy;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (accept && end_of_message) st_d = ST_PAD;
			ST_PAD:  if (pad_go && pos_q == 6'd63) st_d = ST_LOAD;
			         else if (pad_go && pos_q == 6'd55 && !need_len_q) st_d = ST_LEN;
			ST_LEN:  if (pad_go && pos_q == 6'd63) st_d = ST_LOAD;
			ST_LOAD: if (sts.done) st_d = need_len_q ? ST_PAD : ST_EMIT;
			ST_EMIT: if (!rd_pend_q && rd_q == 4'd8 && (!out_valid || !out_stall))
				st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// block word writes
	always_comb begin
		blk_we = 1'b0;
		blk_addr = pos_q[5:2];
		blk_wdata = acc_q;
		if (byte_acc && cur[1:0] == 2'd3) begin
			blk_we = 1'b1;
			blk_addr = cur[5:2];
			blk_wdata = {acc_q[31:8], msg_byte};
		end
		if (pad_go && pos_q[1:0] == 2'd3) begin
			blk_we = 1'b1;
			blk_addr = pos_q[5:2];
			if (st_q == ST_LEN)
				blk_wdata = pos_q[5:2] == 4'd14 ? bits[63:32] : bits[31:0];
			else blk_wdata = {acc_q[31:8], fin_q ? 8'h00 : PAD_BYTE};
		end
	end

	assign cmd.start  = (blk_we && blk_addr == 4'd15) && !sts.busy;
	assign cmd.add_iv = 1'b0;
	assign cv_raddr   = rd_q[2:0];
	assign cv_reinit  = (st_q == ST_EMIT) && st_d == ST_IDLE;

	// data path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			acc_q <= '0;
			pos_q <= '0;
			fin_q <= 1'b0;
			need_len_q <= 1'b0;
			run_q <= 1'b0;
			rd_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid <= 1'b0;
			digest_word <= '0;
			word_index <= '0;
			last_word <= 1'b0;
		end else begin
			st_q <= st_d;
			run_q <= cmd.start;
			if (byte_acc) begin
				cnt_q <= cnt_q + 61'd1;
				acc_q[31 - 8*cur[1:0] -: 8] <= msg_byte;
			end
			if (st_q == ST_IDLE && accept && end_of_message) begin
				pos_q <= byte_acc ? cur + 6'd1 : cur;
				fin_q <= 1'b0;
				need_len_q <= 1'b0;
				if ((byte_acc ? cur + 6'd1 : cur) >= 6'd56 && !(byte_acc && cur == 6'd63))
					need_len_q <= 1'b1;
				// first pad byte
				if (byte_acc && cur == 6'd63) begin
					pos_q <= 6'd0;
				end
			end
			if (pad_go) begin
				pos_q <= pos_q + 6'd1;
				if (st_q == ST_PAD) acc_q[31 - 8*pos_q[1:0] -: 8] <=
					(!fin_q) ? PAD_BYTE : 8'h00;
				if (st_q == ST_PAD) fin_q <= 1'b1;
				if (st_q == ST_PAD && pos_q == 6'd55 && !need_len_q) pos_q <= 6'd56;
			end
			if (st_q == ST_LOAD && sts.done) begin
				pos_q <= 6'd0;
				if (need_len_q) need_len_q <= 1'b0;
			end
			if (st_q == ST_IDLE && !(accept && end_of_message)) fin_q <= 1'b0;
			// digest readout, one word per free output slot
			if (st_q == ST_EMIT) begin
				if (out_valid && !out_stall) out_valid <= 1'b0;
				if (rd_pend_q) begin
					rd_pend_q <= 1'b0;
					out_valid <= 1'b1;
					digest_word <= cv_rdata;
					word_index <= 3'(rd_q - 4'd1);
					last_word <= (rd_q == 4'd8);
				end else if (rd_q != 4'd8 && (!out_valid || !out_stall)
						&& !(out_valid)) begin
					rd_pend_q <= 1'b1;
					rd_q <= rd_q + 4'd1;
				end
				if (st_d == ST_IDLE) begin
					rd_q <= '0;
					cnt_q <= '0;
				end
			end else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end
endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// top level of the sha-256 byte stream hasher
`timescale 1ns / 1ps
// Takes one message byte per beat, packing bytes big-endian into a 16-word
// schedule memory. A byte beat that does not close a 64-byte block is taken
// without a stall. A full block loads the chain value, then for each round runs
// a schedule step and the shared round unit: the first sixteen rounds read their
// stored word, later ones build a new schedule word from four reads of the
// window memory's single read port plus an update step. It then folds the
// result back into the chain value, all with input stalled. On an end beat the
// block pads one byte per cycle while the core is idle, compresses one or two
// blocks and then returns the eight digest words, word 0 first; input stalls
// until the last word has been taken.
module sha256_byte_stream_hasher #(
	parameter int ROUNDS = s256_pkg::ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import s256_pkg::*;

	core_cmd_t   cmd;
	core_sts_t   sts;
	logic        blk_we, cv_reinit;
	logic [3:0]  blk_addr;
	logic [31:0] blk_wdata, cv_rdata;
	logic [2:0]  cv_raddr;

	// control and padding
	s256_ctl u_ctl (
		.clk, .arst_n, .in_valid, .in_stall, .msg_byte, .has_byte, .end_of_message,
		.out_valid, .out_stall, .digest_word, .word_index, .last_word,
		.cmd, .sts, .blk_we, .blk_addr, .blk_wdata, .cv_raddr, .cv_rdata, .cv_reinit
	);

	// compression
	s256_core #(.ROUNDS(ROUNDS)) u_core (
		.clk, .arst_n, .cmd, .sts, .blk_we, .blk_addr, .blk_wdata,
		.cv_raddr, .cv_rdata, .cv_reinit
	);
endmodule

// ----- rtl/s256_chk.sv -----
// port-level checker for the sha-256 hasher and its bind
`timescale 1ns / 1ps
module s256_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word))
		else $error("stalled output changed");
	// last flag only on word seven
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last flag mismatch");
	// no input taken while digest goes out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted during output");
endmodule

bind sha256_byte_stream_hasher s256_chk u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.digest_word, .word_index, .last_word
);

// ----- tb/sha256_byte_stream_hasher_tb.sv -----
// self-checking testbench for the sha-256 byte stream hasher
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_tb;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} byte_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  msg_byte = '0;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	byte_beat_t   pending_bytes[$];
	digest_beat_t expected_words[$];
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_off_cycles = 0;
	int           error_count = 0;
	int           cycle_count = 0;

	// predictor state
	logic [31:0] hash_state [8];
	logic [31:0] block_words [16];
	logic [60:0] byte_count;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.msg_byte(msg_byte), .has_byte(has_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic start_message();
		for (int i = 0; i < 8; i++) hash_state[i] = s256_pkg::IV_TABLE[i];
		for (int i = 0; i < 16; i++) block_words[i] = '0;
		byte_count = '0;
	endtask

	// one 64-round compression of block_words into hash_state
	task automatic run_rounds();
		logic [31:0] w [64];
		logic [31:0] r [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++) w[t] = block_words[t];
		for (int t = 16; t < 64; t++)
			w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
				(ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (int i = 0; i < 8; i++) r[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25)) +
				((r[4] & r[5]) ^ (~r[4] & r[6])) + s256_pkg::RC_TABLE[t] + w[t];
			t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22)) +
				((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
			for (int i = 7; i > 0; i--) r[i] = r[i-1];
			r[0] = t1 + t2;
			r[4] = r[4] + t1;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + r[i];
	endtask

	task automatic place_byte(input int pos, input logic [7:0] b);
		int sh;
		sh = 24 - 8 * (pos % 4);
		if (pos % 4 == 0) block_words[pos / 4] = 32'(b) << sh;
		else block_words[pos / 4] |= 32'(b) << sh;
	endtask

	// predict digest words caused by one accepted byte beat
	task automatic predict_digest(input byte_beat_t bt);
		int pos;
		logic [63:0] bits;
		digest_beat_t d;
		if (bt.has_byte) begin
			pos = int'(byte_count[5:0]);
			place_byte(pos, bt.msg_byte);
			byte_count = byte_count + 61'd1;
			if (pos == 63) run_rounds();
		end
		if (bt.end_of_message) begin
			pos = int'(byte_count[5:0]);
			place_byte(pos, s256_pkg::PAD_BYTE);
			for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
			if (pos >= 56) begin
				run_rounds();
				for (int i = 0; i < 16; i++) block_words[i] = '0;
			end
			bits = {byte_count, 3'b000};
			block_words[14] = bits[63:32];
			block_words[15] = bits[31:0];
			run_rounds();
			for (int i = 0; i < 8; i++) begin
				d.digest_word = hash_state[i];
				d.word_index = 3'(i);
				d.last_word = (i == 7);
				expected_words = {expected_words, d};
			end
			start_message();
		end
	endtask

	// driver: offers queued beats, holds payload while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_digest({msg_byte, has_byte, end_of_message});
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_beat_t bt;
					bt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					msg_byte <= bt.msg_byte;
					has_byte <= bt.has_byte;
					end_of_message <= bt.end_of_message;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks digest beats and drives receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected digest beat %h", digest_word);
					error_count++;
				end else begin
					digest_beat_t e;
					e = expected_words.pop_front();
					if (digest_word !== e.digest_word) begin
						$error("digest_word expected %h actual %h", e.digest_word, digest_word);
						error_count++;
					end
					if (word_index !== e.word_index) begin
						$error("word_index expected %0d actual %0d", e.word_index, word_index);
						error_count++;
					end
					if (last_word !== e.last_word) begin
						$error("last_word expected %0d actual %0d", e.last_word, last_word);
						error_count++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_message(input int len, input bit empty_tail);
		byte_beat_t bt;
		for (int i = 0; i < len; i++) begin
			bt.msg_byte = 8'($urandom);
			bt.has_byte = 1'b1;
			bt.end_of_message = (i == len - 1) && !empty_tail;
			pending_bytes = {pending_bytes, bt};
			// occasional ignored idle beat in the middle
			if ($urandom_range(19) == 0) begin
				bt.msg_byte = 8'($urandom);
				bt.has_byte = 1'b0;
				bt.end_of_message = 1'b0;
				pending_bytes = {pending_bytes, bt};
			end
		end
		if (empty_tail || len == 0) begin
			bt.msg_byte = 8'($urandom);
			bt.has_byte = 1'b0;
			bt.end_of_message = 1'b1;
			pending_bytes = {pending_bytes, bt};
		end
	endtask

	// sampled away from the active edge so driver updates have settled
	task automatic wait_drained();
		@(negedge clk);
		while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = $urandom_range(55, 64);
				2: len = $urandom_range(119, 129);
				default: len = $urandom_range(1, 40);
			endcase
			queue_message(len, $urandom_range(3) == 0);
			sent += len + 1;
		end
	endtask

	initial begin
		byte_beat_t bt;
		start_message();
		send_idle_pct = 16;
		recv_idle_pct = 63;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty message, idle beat, extremes of byte, pad boundaries
		bt = '{8'hff, 1'b0, 1'b0};
		pending_bytes = {pending_bytes, bt};
		queue_message(0, 1'b1);
		bt = '{8'h00, 1'b1, 1'b1};
		pending_bytes = {pending_bytes, bt};
		bt = '{8'hff, 1'b1, 1'b1};
		pending_bytes = {pending_bytes, bt};
		bt = '{8'h61, 1'b1, 1'b0};
		pending_bytes = {pending_bytes, bt};
		bt = '{8'h00, 1'b0, 1'b1};
		pending_bytes = {pending_bytes, bt};
		queue_message(55, 1'b0);
		queue_message(56, 1'b0);
		queue_message(63, 1'b1);
		queue_message(64, 1'b0);
		wait_drained();

		queue_random(30);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		hold_off_cycles = 3000;
		queue_random(30);
		wait_drained();

		send_idle_pct = 63;
		recv_idle_pct = 16;
		queue_random(30);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(30);
		wait_drained();

		if (expected_words.size() != 0) begin
			$error("digest_word expected %0d more beats actual 0", expected_words.size());
			error_count++;
		end
		if (error_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
